### sv/gs1p_pkg.sv
// ----------------------------------------------------------------------------
// gs1p_pkg: shared types and tables for the GS1 element string parser
// Holds the byte class record that travels from front to back, the result
// status codes and the application identifier table.
// ----------------------------------------------------------------------------
`default_nettype none

package gs1p_pkg;

   // Group separator byte.
   localparam logic [7:0] GS_BYTE = 8'h1D;

   // Number of entries in the application identifier table.
   localparam int AI_COUNT = 26;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_PROGRESS = 2'd0,
      ST_ACCEPT   = 2'd1,
      ST_REJECT   = 2'd2
   } status_type;

   // Parser phase, one-hot.
   typedef enum logic [2:0] {
      PH_AI    = 3'b001,
      PH_FIELD = 3'b010,
      PH_ERROR = 3'b100
   } phase_type;

   // One queued transaction together with the class of its byte.
   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic       is_digit;
      logic       is_alnum;
      logic       is_gs;
   } item_type;

   // Result of looking up a prefix value in the table.
   typedef struct packed {
      logic       found;
      logic [4:0] index;
   } ai_match_type;

   // Maps a prefix value to its table position.
   function automatic ai_match_type ai_lookup(input logic [8:0] value);
      ai_match_type m;
      m.found = 1'b1;
      unique case (value)
         9'd0:    m.index = 5'd0;
         9'd1:    m.index = 5'd1;
         9'd2:    m.index = 5'd2;
         9'd10:   m.index = 5'd3;
         9'd11:   m.index = 5'd4;
         9'd12:   m.index = 5'd5;
         9'd13:   m.index = 5'd6;
         9'd15:   m.index = 5'd7;
         9'd16:   m.index = 5'd8;
         9'd17:   m.index = 5'd9;
         9'd20:   m.index = 5'd10;
         9'd21:   m.index = 5'd11;
         9'd22:   m.index = 5'd12;
         9'd240:  m.index = 5'd13;
         9'd241:  m.index = 5'd14;
         9'd311:  m.index = 5'd15;
         9'd90:   m.index = 5'd16;
         9'd91:   m.index = 5'd17;
         9'd92:   m.index = 5'd18;
         9'd93:   m.index = 5'd19;
         9'd94:   m.index = 5'd20;
         9'd95:   m.index = 5'd21;
         9'd96:   m.index = 5'd22;
         9'd97:   m.index = 5'd23;
         9'd98:   m.index = 5'd24;
         9'd99:   m.index = 5'd25;
         default: begin
            m.found = 1'b0;
            m.index = 5'd0;
         end
      endcase
      return m;
   endfunction

   // Field length (exact for fixed fields, maximum for variable fields).
   function automatic logic [6:0] ai_length(input logic [4:0] index);
      logic [6:0] len;
      unique case (index) inside
         5'd0:                        len = 7'd18;
         5'd1, 5'd2:                  len = 7'd14;
         5'd3, 5'd11, 5'd12:          len = 7'd20;
         5'd4, 5'd5, 5'd6, 5'd7,
         5'd8, 5'd9:                  len = 7'd6;
         5'd10:                       len = 7'd2;
         5'd13, 5'd14, 5'd16:         len = 7'd30;
         5'd15:                       len = 7'd7;
         default:                     len = 7'd90;
      endcase
      return len;
   endfunction

   // True for identifiers whose field is of variable length.
   function automatic logic ai_variable(input logic [4:0] index);
      logic var_len;
      unique case (index) inside
         5'd3, 5'd11, 5'd12, 5'd13, 5'd14: var_len = 1'b1;
         default: var_len = (index >= 5'd16);
      endcase
      return var_len;
   endfunction

endpackage

`default_nettype wire

### sv/gs1p_front.sv
// ----------------------------------------------------------------------------
// gs1p_front: byte classifier and two-entry queue
// Accepts request transactions, tags each byte with its character class and
// holds it until the parser core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gs1p_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_command,
   input  wire logic [7:0]        req_data_byte,
   output logic                   q_valid,
   output gs1p_pkg::item_type     q_item,
   input  wire logic              q_pop
);
   import gs1p_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push;
   logic [7:0] b;

   // Character classes of the incoming byte.
   always_comb begin
      b = req_data_byte;
      new_item.command   = req_command;
      new_item.data_byte = req_data_byte;
      new_item.is_digit  = (b >= 8'h30) && (b <= 8'h39);
      new_item.is_gs     = (b == GS_BYTE);
      // Digits and the punctuation set happen to fill 0x25 through 0x3F.
      new_item.is_alnum  = (b == 8'h21) || (b == 8'h22) ||
                           ((b >= 8'h25) && (b <= 8'h3F)) ||
                           ((b >= 8'h41) && (b <= 8'h5A)) ||
                           (b == 8'h5F) ||
                           ((b >= 8'h61) && (b <= 8'h7A));
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

### sv/gs1p_back.sv
// ----------------------------------------------------------------------------
// gs1p_back: parser core and result register
// Runs the element string state machine on one queued byte per cycle when the
// result register can accept, holding the result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gs1p_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire gs1p_pkg::item_type q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [4:0]             rsp_ai_index,
   output logic [7:0]             rsp_data_byte_out,
   output logic                   rsp_has_byte,
   output logic                   rsp_item_end,
   output logic [1:0]             rsp_status
);
   import gs1p_pkg::*;

   phase_type    phase_ff, phase_in;
   logic [6:0]   prefix_digits_ff, prefix_digits_in;
   logic [1:0]   prefix_count_ff, prefix_count_in;
   logic [4:0]   current_ai_ff, current_ai_in;
   logic [6:0]   field_count_ff, field_count_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [4:0]   ai_ff, ai_in;
   logic [7:0]   byte_ff, byte_in;
   logic         has_byte_ff, has_byte_in;
   logic         item_end_ff, item_end_in;
   status_type   status_ff, status_in;

   logic         produce;
   logic [8:0]   prefix_value;
   ai_match_type match;
   logic [6:0]   len;
   logic         var_len;
   logic [6:0]   count_next;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   // Prefix value and table lookup.
   always_comb begin
      prefix_value = 9'(prefix_digits_ff) * 9'd10 + 9'(q_item.data_byte[3:0]);
      match        = ai_lookup(prefix_value);
      len          = ai_length(current_ai_ff);
      var_len      = ai_variable(current_ai_ff);
      count_next   = field_count_ff + 7'd1;
   end

   // Parser state machine.
   always_comb begin
      phase_in         = phase_ff;
      prefix_digits_in = prefix_digits_ff;
      prefix_count_in  = prefix_count_ff;
      current_ai_in    = current_ai_ff;
      field_count_in   = field_count_ff;
      produce          = 1'b0;
      ai_in            = 5'd0;
      byte_in          = 8'd0;
      has_byte_in      = 1'b0;
      item_end_in      = 1'b0;
      status_in        = ST_PROGRESS;

      if (q_item.command) begin
         // End of message: report the verdict (none from the error phase) and restart.
         unique case (phase_ff)
            PH_AI: begin
               produce   = 1'b1;
               status_in = (prefix_count_ff == 2'd0) ? ST_ACCEPT : ST_REJECT;
            end
            PH_FIELD: begin
               produce = 1'b1;
               if (var_len) begin
                  ai_in       = current_ai_ff;
                  item_end_in = 1'b1;
                  status_in   = ST_ACCEPT;
               end else begin
                  status_in = ST_REJECT;
               end
            end
            default: produce = 1'b0;
         endcase
         phase_in         = PH_AI;
         prefix_digits_in = 7'd0;
         prefix_count_in  = 2'd0;
         current_ai_in    = 5'd0;
         field_count_in   = 7'd0;
      end else begin
         unique case (phase_ff)
            PH_AI: begin
               if (!q_item.is_digit) begin
                  produce   = 1'b1;
                  status_in = ST_REJECT;
                  phase_in  = PH_ERROR;
               end else if (prefix_count_ff == 2'd0) begin
                  prefix_digits_in = 7'(q_item.data_byte[3:0]);
                  prefix_count_in  = 2'd1;
               end else if (match.found) begin
                  current_ai_in    = match.index;
                  field_count_in   = 7'd0;
                  prefix_digits_in = 7'd0;
                  prefix_count_in  = 2'd0;
                  phase_in         = PH_FIELD;
               end else if ((prefix_count_ff == 2'd1) &&
                            ((prefix_value == 9'd24) || (prefix_value == 9'd31))) begin
                  prefix_digits_in = prefix_value[6:0];
                  prefix_count_in  = 2'd2;
               end else begin
                  produce   = 1'b1;
                  status_in = ST_REJECT;
                  phase_in  = PH_ERROR;
               end
            end
            PH_FIELD: begin
               if (var_len && q_item.is_gs) begin
                  // Separator closes a variable field.
                  produce        = 1'b1;
                  ai_in          = current_ai_ff;
                  item_end_in    = 1'b1;
                  phase_in       = PH_AI;
                  field_count_in = 7'd0;
               end else if ((field_count_ff >= len) ||
                            (var_len ? !q_item.is_alnum : !q_item.is_digit)) begin
                  produce   = 1'b1;
                  status_in = ST_REJECT;
                  phase_in  = PH_ERROR;
               end else begin
                  produce        = 1'b1;
                  ai_in          = current_ai_ff;
                  byte_in        = q_item.data_byte;
                  has_byte_in    = 1'b1;
                  field_count_in = count_next;
                  // A fixed field ends at its exact count.
                  if (!var_len && (count_next >= len)) begin
                     item_end_in    = 1'b1;
                     phase_in       = PH_AI;
                     field_count_in = 7'd0;
                  end
               end
            end
            default: produce = 1'b0;
         endcase
      end
   end

   // Result register hand-off.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (q_pop) begin
         rsp_valid_in = produce;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_AI;
         prefix_digits_ff <= 7'd0;
         prefix_count_ff  <= 2'd0;
         current_ai_ff    <= 5'd0;
         field_count_ff   <= 7'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff         <= phase_in;
            prefix_digits_ff <= prefix_digits_in;
            prefix_count_ff  <= prefix_count_in;
            current_ai_ff    <= current_ai_in;
            field_count_ff   <= field_count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (q_pop && produce) begin
         ai_ff       <= ai_in;
         byte_ff     <= byte_in;
         has_byte_ff <= has_byte_in;
         item_end_ff <= item_end_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ai_index      = ai_ff;
   assign rsp_data_byte_out = byte_ff;
   assign rsp_has_byte      = has_byte_ff;
   assign rsp_item_end      = item_end_ff;
   assign rsp_status        = status_ff;

endmodule

`default_nettype wire

### sv/gs1_element_string_parser.sv
// ----------------------------------------------------------------------------
// gs1_element_string_parser: streaming GS1 element string parser
// Recognizes application identifier prefixes, checks field characters and
// lengths, and reports each data byte, element end and message verdict.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid/req_ready    req_command, req_data_byte
//  rsp      out        rsp_valid/rsp_ready    rsp_ai_index, rsp_data_byte_out,
//                                             rsp_has_byte, rsp_item_end,
//                                             rsp_status
//
//  One byte per cycle is sustained while rsp_ready is high: the parser core
//  handles one queued transaction each cycle that its result register is
//  free or being taken. A result passes through a queue entry, then the
//  result register. Synchronous reset returns the parser to expecting AI
//  digits and empties the queue and the result register. When rsp_ready
//  is low the two-entry queue absorbs input before req_ready drops.
//
`default_nettype none

module gs1_element_string_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [4:0]       rsp_ai_index,
   output logic [7:0]       rsp_data_byte_out,
   output logic             rsp_has_byte,
   output logic             rsp_item_end,
   output logic [1:0]       rsp_status
);
   import gs1p_pkg::*;

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   // Classifier and queue.
   gs1p_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   // Parser core and result register.
   gs1p_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ai_index      (rsp_ai_index),
      .rsp_data_byte_out (rsp_data_byte_out),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_item_end      (rsp_item_end),
      .rsp_status        (rsp_status)
   );

endmodule

`default_nettype wire
